>>> sv/stsm_pkg.sv
// Shared types and constants for the sorted table membership search core.
`default_nettype none

package stsm_pkg;

    localparam int VALUE_W       = 32;
    localparam int KIND_W        = 2;
    localparam int DEF_TABLE_DEPTH = 1024;
    // Item queue between front and back; depth must be a power of two.
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_LOAD,
        OP_QUERY
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [VALUE_W-1:0]  value;
        logic                       last;
    } item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SEARCH,
        BK_HOLD
    } back_state_t;

endpackage

`default_nettype wire

>>> sv/stsm_front.sv
// Front end: accepts stream transfers, decodes the kind and queues items for the back end.
`default_nettype none

module stsm_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [stsm_pkg::VALUE_W-1:0]      s_tdata,   // [31:0] value
    input  wire logic [stsm_pkg::KIND_W-1:0]       s_tuser,   // [1:0] kind
    input  wire logic                              s_tlast,
    output stsm_pkg::item_t                        item,
    output logic                                   item_valid,
    input  wire logic                              item_pop
);
    import stsm_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t               queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   fill_reg, fill_next;
    item_t               decoded;
    logic                kind_ok;
    logic                push;
    logic                pop;

    // Classify the incoming transfer; the unused kind is taken and dropped.
    always_comb
    begin
        decoded.value = $signed(s_tdata);
        decoded.last  = s_tlast;
        decoded.op    = OP_CLEAR;
        kind_ok       = 1'b1;
        case (s_tuser)
            KIND_CLEAR: decoded.op = OP_CLEAR;
            KIND_LOAD:  decoded.op = OP_LOAD;
            KIND_QUERY: decoded.op = OP_QUERY;
            default:    kind_ok    = 1'b0;
        endcase
    end

    assign s_tready   = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready && kind_ok;
    assign item_valid = (fill_reg != '0);
    assign pop        = item_pop && item_valid;
    assign item       = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

>>> sv/stsm_back.sv
// Back end: table memory, entry count, bisection sequencer and output register.
`default_nettype none

module stsm_back #(
    parameter int TABLE_DEPTH = stsm_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire stsm_pkg::item_t                   item,
    input  wire logic                              item_valid,
    output logic                                   item_pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [stsm_pkg::VALUE_W-1:0]           m_tdata,   // [31:0] query_value
    output logic [1:0]                             m_tuser,   // [0] found, [1] overflow
    output logic                                   m_tlast
);
    import stsm_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    logic signed [VALUE_W-1:0] table_mem [TABLE_DEPTH];

    back_state_t               state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      dropped_reg, dropped_next;
    // Search window is [lo, hip): hip is one past the upper bound.
    logic [CNT_W-1:0]          lo_reg, lo_next;
    logic [CNT_W-1:0]          hip_reg, hip_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;
    logic                      last_reg, last_next;
    logic                      found_reg, found_next;
    logic signed [VALUE_W-1:0] rdata_reg;
    logic                      m_valid_reg, m_valid_next;
    logic signed [VALUE_W-1:0] m_value_reg;
    logic                      m_found_reg;
    logic                      m_last_reg;
    logic                      m_ovf_reg;

    logic                      rd_en;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic                      out_load;
    logic                      out_free;
    logic                      table_full;
    logic [ADDR_W-1:0]         cur_mid;
    logic [ADDR_W-1:0]         new_mid;
    logic                      hit;
    logic                      go_up;
    logic [CNT_W-1:0]          lo_step;
    logic [CNT_W-1:0]          hip_step;
    logic                      more;

    function automatic logic [ADDR_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                                  input logic [CNT_W-1:0] hip);
        logic [CNT_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hip} - (CNT_W+1)'(1);
        return sum[ADDR_W:1];
    endfunction

    assign out_free   = !m_valid_reg || m_tready;
    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));

    // One bisection step on the entry read in the previous cycle.
    always_comb
    begin
        cur_mid  = mid_of(lo_reg, hip_reg);
        hit      = (rdata_reg == key_reg);
        go_up    = (rdata_reg < key_reg);
        lo_step  = go_up ? CNT_W'(cur_mid) + CNT_W'(1) : lo_reg;
        hip_step = go_up ? hip_reg : CNT_W'(cur_mid);
        more     = (lo_step < hip_step);
        new_mid  = mid_of(lo_step, hip_step);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (item_valid && item.op == OP_QUERY)
                begin
                    state_next = (count_reg == '0) ? BK_HOLD : BK_SEARCH;
                end
            end
            BK_SEARCH:
            begin
                if (hit || !more)
                begin
                    state_next = BK_HOLD;
                end
            end
            BK_HOLD:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        item_pop = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                item_pop = item_valid;
                if (item_valid && item.op == OP_QUERY && count_reg != '0)
                begin
                    rd_en   = 1'b1;
                    rd_addr = mid_of('0, count_reg);
                end
                wr_en = item_valid && item.op == OP_LOAD && !table_full;
            end
            BK_SEARCH:
            begin
                if (!hit && more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = new_mid;
                end
            end
            BK_HOLD:
            begin
                out_load = out_free;
            end
            default:
            begin
                item_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        lo_next      = lo_reg;
        hip_next     = hip_reg;
        key_next     = key_reg;
        last_next    = last_reg;
        found_next   = found_reg;
        if (state_reg == BK_IDLE && item_valid)
        begin
            case (item.op)
                OP_CLEAR:
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                end
                OP_LOAD:
                begin
                    if (table_full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_QUERY:
                begin
                    lo_next    = '0;
                    hip_next   = count_reg;
                    key_next   = item.value;
                    last_next  = item.last;
                    found_next = 1'b0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        else if (state_reg == BK_SEARCH)
        begin
            lo_next    = lo_step;
            hip_next   = hip_step;
            found_next = hit;
        end
        m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hip_reg   <= hip_next;
        key_reg   <= key_next;
        last_reg  <= last_next;
        found_reg <= found_next;
        if (out_load)
        begin
            m_value_reg <= key_reg;
            m_found_reg <= found_reg;
            m_last_reg  <= last_reg;
            m_ovf_reg   <= dropped_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[count_reg[ADDR_W-1:0]] <= item.value;
        end
        if (rd_en)
        begin
            rdata_reg <= table_mem[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = {m_ovf_reg, m_found_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

>>> sv/sorted_table_membership_search_core.sv
// Top level of the sorted table membership search core.
// Items enter on the s_ stream: tuser carries the kind (clear, load, query), tdata the
// signed value and tlast the end-of-list mark; kind 3 is taken and ignored. Loads append
// to a table of TABLE_DEPTH entries; the user must load them in ascending order, which
// the block itself does not enforce. Loads into a full table are dropped and raise the
// sticky overflow flag until the next clear. Each query returns one transfer on the m_
// stream with the queried value in tdata, found and overflow in tuser and the echoed mark
// in tlast. The back end takes a clear or load in its idle state; a query runs at most
// ceil(log2(count + 1)) bisection probes and waits in a hold state until the output is
// free. The table memory gives one registered read per cycle and each probe waits on it.
// A two-entry queue lets the input side keep taking items while a search runs or a result waits.
`default_nettype none

module sorted_table_membership_search_core #(
    parameter int TABLE_DEPTH = stsm_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [stsm_pkg::VALUE_W-1:0]      s_tdata,   // [31:0] value
    input  wire logic [stsm_pkg::KIND_W-1:0]       s_tuser,   // [1:0] kind
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [stsm_pkg::VALUE_W-1:0]           m_tdata,   // [31:0] query_value
    output logic [1:0]                             m_tuser,   // [0] found, [1] overflow
    output logic                                   m_tlast
);
    import stsm_pkg::*;

    item_t item;
    logic  item_valid;
    logic  item_pop;

    stsm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    stsm_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
